### rtl/core/sfe_pkg.sv
// Shared types and constants for the step function evaluator.
// Holds table geometry, payload structs, codes and the sequencer state type.
// No dependencies; every other file in rtl/core but sfe_ram uses this package.
package sfe_pkg;

  // Table geometry.
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 8;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int TABLE_DEPTH = 1 << ADDR_W;

  // Fixed field widths of the channels.
  localparam int IN_ROW_W   = 10;
  localparam int COLUMN_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int REGION_W   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_CNT_W  = 11;
  localparam int COL_CNT_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_LEFT_OPEN    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [REGION_W-1:0] {
    REGION_BEFORE = 2'd0,
    REGION_WITHIN = 2'd1,
    REGION_AFTER  = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SCAN,
    ST_PREP,
    ST_EMIT
  } state_e;

  // Input item.
  typedef struct packed {
    cmd_e                        command;
    logic [IN_ROW_W-1:0]         row;
    logic [COLUMN_W-1:0]         column;
    logic signed [VALUE_W-1:0]   value;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [COLUMN_W-1:0]         column_res;
    logic signed [VALUE_W-1:0]   value_res;
    region_e                     region;
    logic [IN_ROW_W-1:0]         row_found;
    logic                        last;
  } out_t;

  // Effective configuration seen by the sequencer.
  typedef struct packed {
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;
    logic             left_open;
  } cfg_t;

  // Result of the shared time comparator.
  typedef struct packed {
    logic reached;
    logic above;
  } cmp_t;

endpackage

### rtl/core/sfe_in_if.sv
// Input channel of the step function evaluator: valid, ready and one item.
// Depends on sfe_pkg for the payload type.
interface sfe_in_if;
  logic         valid;
  logic         ready;
  sfe_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sfe_out_if.sv
// Result channel of the step function evaluator: valid, ready and one result.
// Depends on sfe_pkg for the payload type.
interface sfe_out_if;
  logic          valid;
  logic          ready;
  sfe_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sfe_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sfe_cmp.sv
// Shared signed time comparator used at every step of the row search.
// Depends on sfe_pkg for the result struct.
module sfe_cmp (
  input  logic signed [sfe_pkg::VALUE_W-1:0] t_i,
  input  logic signed [sfe_pkg::VALUE_W-1:0] x_i,
  input  logic                               strict_i,
  output sfe_pkg::cmp_t                      res_o
);

  logic lt;
  logic eq;

  // A signed less-than compare and an equality test give the reached and above flags.
  assign lt = (t_i < x_i);
  assign eq = (t_i == x_i);

  assign res_o.above   = lt;
  assign res_o.reached = lt | (~strict_i & eq);

endmodule

### rtl/core/sfe_seq.sv
// Query sequencer: walks the table time column through the RAM read port,
// drives the shared comparator and emits the result beats.
// Depends on sfe_pkg, sfe_in_if, sfe_out_if and sfe_cmp.
module sfe_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sfe_in_if.sink                       in_i,
  sfe_out_if.source                    out_o,
  input  sfe_pkg::cfg_t                cfg_i,
  input  logic [sfe_pkg::VALUE_W-1:0]  rdata_i,
  output logic [sfe_pkg::ADDR_W-1:0]   raddr_o
);

  sfe_pkg::state_e                    state_q, state_d;
  logic signed [sfe_pkg::VALUE_W-1:0] x_q;
  logic                               strict_q;
  logic [sfe_pkg::ROW_W-1:0]          r_q;
  logic [sfe_pkg::ROW_W-1:0]          sel_q;
  sfe_pkg::region_e                   region_q;
  logic [sfe_pkg::COL_W-1:0]          k_q;
  logic                               ovalid_q;
  sfe_pkg::out_t                      out_q;

  sfe_pkg::cmp_t                      cmp;
  logic                               query_fire;
  logic                               slot_free;
  logic                               beat_load;
  logic                               beat_last;
  sfe_pkg::out_t                      beat;

  // Shared comparator: table time from the RAM against the query time.
  sfe_cmp u_cmp (
    .t_i      (rdata_i),
    .x_i      (x_q),
    .strict_i (strict_q),
    .res_o    (cmp)
  );

  assign query_fire = in_i.valid && in_i.ready && (in_i.data.command == sfe_pkg::CMD_QUERY);
  assign slot_free  = ~ovalid_q | out_o.ready;
  assign beat_last  = (k_q == cfg_i.last_col);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfe_pkg::ST_IDLE: begin
        if (query_fire) state_d = sfe_pkg::ST_CHK_FIRST;
      end
      sfe_pkg::ST_CHK_FIRST: begin
        state_d = cmp.reached ? sfe_pkg::ST_CHK_LAST : sfe_pkg::ST_PREP;
      end
      sfe_pkg::ST_CHK_LAST: begin
        state_d = (cmp.above | cmp.reached) ? sfe_pkg::ST_PREP : sfe_pkg::ST_SCAN;
      end
      sfe_pkg::ST_SCAN: begin
        if (cmp.reached) state_d = sfe_pkg::ST_PREP;
      end
      sfe_pkg::ST_PREP: begin
        state_d = sfe_pkg::ST_EMIT;
      end
      sfe_pkg::ST_EMIT: begin
        if (slot_free) state_d = beat_last ? sfe_pkg::ST_IDLE : sfe_pkg::ST_PREP;
      end
      default: state_d = sfe_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: read address, input ready and beat load.
  always_comb begin
    raddr_o   = '0;
    in_i.ready = 1'b0;
    beat_load = 1'b0;
    case (state_q)
      sfe_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        raddr_o    = '0;
      end
      sfe_pkg::ST_CHK_FIRST: begin
        raddr_o = {cfg_i.last_row, {sfe_pkg::COL_W{1'b0}}};
      end
      sfe_pkg::ST_CHK_LAST: begin
        raddr_o = {cfg_i.last_row - sfe_pkg::ROW_W'(1), {sfe_pkg::COL_W{1'b0}}};
      end
      sfe_pkg::ST_SCAN: begin
        raddr_o = {r_q - sfe_pkg::ROW_W'(1), {sfe_pkg::COL_W{1'b0}}};
      end
      sfe_pkg::ST_PREP: begin
        raddr_o = {sel_q, k_q};
      end
      sfe_pkg::ST_EMIT: begin
        raddr_o   = {sel_q, k_q};
        beat_load = slot_free;
      end
      default: begin
        raddr_o = '0;
      end
    endcase
  end

  // Result beat: the query time first, then the row values or zero.
  always_comb begin
    beat.column_res = sfe_pkg::COLUMN_W'(k_q);
    beat.region     = region_q;
    beat.row_found  = sfe_pkg::IN_ROW_W'(sel_q);
    beat.last       = beat_last;
    if (k_q == '0) begin
      beat.value_res = x_q;
    end else if (region_q == sfe_pkg::REGION_BEFORE) begin
      beat.value_res = '0;
    end else begin
      beat.value_res = rdata_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfe_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (beat_load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Query registers and the search outcome.
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      x_q      <= in_i.data.value;
      strict_q <= cfg_i.left_open;
    end
    case (state_q)
      sfe_pkg::ST_CHK_FIRST: begin
        k_q <= '0;
        if (!cmp.reached) begin
          region_q <= sfe_pkg::REGION_BEFORE;
          sel_q    <= '0;
        end
      end
      sfe_pkg::ST_CHK_LAST: begin
        sel_q    <= cfg_i.last_row;
        r_q      <= cfg_i.last_row - sfe_pkg::ROW_W'(1);
        region_q <= cmp.above ? sfe_pkg::REGION_AFTER : sfe_pkg::REGION_WITHIN;
      end
      sfe_pkg::ST_SCAN: begin
        if (cmp.reached) begin
          sel_q    <= r_q;
          region_q <= sfe_pkg::REGION_WITHIN;
        end else begin
          r_q <= r_q - sfe_pkg::ROW_W'(1);
        end
      end
      sfe_pkg::ST_EMIT: begin
        if (beat_load) k_q <= k_q + sfe_pkg::COL_W'(1);
      end
      default: begin
      end
    endcase
    if (beat_load) begin
      out_q <= beat;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = out_q;

endmodule

### rtl/core/step_function_evaluator.sv
// Step function evaluator. A load item (command 0) writes one word of the
// table at row/column; it is taken while idle and gives no result. A query
// item (command 1) carries a time x. The block picks the highest row whose
// time is at most x (strictly below x in left-open mode) and emits column
// 0 to column_count-1: x itself, then that row's values, the last marked.
// Before the first time the values are zero; after the last time the last
// row's values are given. Registers row_count, column_count and left_open
// are written on the plain write port; the user must write them only while
// the block is idle, as the block itself does not enforce it. For a query
// the first and last row times are checked (only the first when x lies
// before the first time), then further rows are scanned downward from the
// last row (up to row_count-1 rows), then each result beat passes through
// a prepare and an emit state. All table reads share the single read port
// of the table RAM and one comparator; the input is not ready during a query.
// Reset clears the registers and the sequencer; the table holds no defined
// contents and needs no clearing pass. A result waits in the output
// register while the receiver stalls; the next beat waits behind it.
module step_function_evaluator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sfe_in_if.sink                           in_i,
  sfe_out_if.source                        out_o
);

  logic [sfe_pkg::ROW_CNT_W-1:0] row_count_q;
  logic [sfe_pkg::COL_CNT_W-1:0] column_count_q;
  logic                          left_open_q;
  sfe_pkg::cfg_t                 cfg;

  logic                          ram_we;
  logic [sfe_pkg::ADDR_W-1:0]    ram_waddr;
  logic [sfe_pkg::ADDR_W-1:0]    ram_raddr;
  logic [sfe_pkg::VALUE_W-1:0]   ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= sfe_pkg::ROW_CNT_W'(1);
      column_count_q <= sfe_pkg::COL_CNT_W'(1);
      left_open_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfe_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data_i[sfe_pkg::ROW_CNT_W-1:0];
        sfe_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data_i[sfe_pkg::COL_CNT_W-1:0];
        sfe_pkg::CFG_LEFT_OPEN:    left_open_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the counts to the table size; zero acts as one.
  always_comb begin
    if (row_count_q == '0) begin
      cfg.last_row = '0;
    end else if (32'(row_count_q) > sfe_pkg::MAX_ROWS) begin
      cfg.last_row = sfe_pkg::ROW_W'(sfe_pkg::MAX_ROWS - 1);
    end else begin
      cfg.last_row = sfe_pkg::ROW_W'(row_count_q - sfe_pkg::ROW_CNT_W'(1));
    end
    if (column_count_q == '0) begin
      cfg.last_col = '0;
    end else if (32'(column_count_q) > sfe_pkg::MAX_COLS) begin
      cfg.last_col = sfe_pkg::COL_W'(sfe_pkg::MAX_COLS - 1);
    end else begin
      cfg.last_col = sfe_pkg::COL_W'(column_count_q - sfe_pkg::COL_CNT_W'(1));
    end
    cfg.left_open = left_open_q;
  end

  // Load transfers write the table directly; out-of-range words are dropped.
  assign ram_we = in_i.valid && in_i.ready
                  && (in_i.data.command == sfe_pkg::CMD_LOAD)
                  && (32'(in_i.data.row) < sfe_pkg::MAX_ROWS)
                  && (32'(in_i.data.column) < sfe_pkg::MAX_COLS);
  assign ram_waddr = {sfe_pkg::ROW_W'(in_i.data.row), sfe_pkg::COL_W'(in_i.data.column)};

  sfe_ram #(
    .WIDTH (sfe_pkg::VALUE_W),
    .DEPTH (sfe_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.data.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfe_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .cfg_i   (cfg),
    .rdata_i (ram_rdata),
    .raddr_o (ram_raddr)
  );

  // A query keeps the input closed in the following cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.data.command == sfe_pkg::CMD_QUERY)
    |=> !in_i.ready)
    else $error("input ready right after a query transfer");

  // Before the first time every value beat is zero.
  a_before_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.region == sfe_pkg::REGION_BEFORE)
    && (out_o.data.column_res != '0)
    |-> (out_o.data.value_res == '0) && (out_o.data.row_found == '0))
    else $error("nonzero result before the first time");

  // The final beat of a query sits in the last configured column.
  a_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.last
    |-> (out_o.data.column_res == sfe_pkg::COLUMN_W'(cfg.last_col)))
    else $error("last beat not in the last column");

  // The row reported after the last time is the last row in use.
  a_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.region == sfe_pkg::REGION_AFTER)
    |-> (out_o.data.row_found == sfe_pkg::IN_ROW_W'(cfg.last_row)))
    else $error("row after the last time is not the last row");

endmodule

### test/tb_top.sv
// Self-checking testbench for step_function_evaluator: table loads, step lookups and registers.
// Depends on sfe_pkg, sfe_in_if, sfe_out_if and the step_function_evaluator RTL.
`timescale 1ns / 100ps

module tb_top;
  import sfe_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int SPARSE_ROWS  = 64;
  localparam int BAND_ROWS    = 8;
  localparam int TIME_MIN     = int'(32'h8000_0000);
  localparam int TIME_MAX     = int'(32'h7fff_ffff);
  // Register index past the end of the register list; writes to it do nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // Keeps its own copy of the table and registers, works out the beats of each
  // lookup and compares the beats that the block delivers against them.
  class step_lookup_board;
    int                   step_table [MAX_ROWS][MAX_COLS];
    logic [ROW_CNT_W-1:0] row_count;
    logic [COL_CNT_W-1:0] column_count;
    bit                   left_open;
    out_t                 pending_beats [$];
    int                   error_count;

    function new();
      row_count    = 1;
      column_count = 1;
      left_open    = 1'b0;
      error_count  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROW_COUNT:    row_count    = data[ROW_CNT_W-1:0];
        CFG_COLUMN_COUNT: column_count = data[COL_CNT_W-1:0];
        CFG_LEFT_OPEN:    left_open    = data[0];
        default: ;
      endcase
    endfunction

    // A jump time counts once the query time has reached it.
    function bit time_reached(int jump, int x);
      return left_open ? (jump < x) : (jump <= x);
    endfunction

    // Loads update the table; a lookup queues one beat per column in use.
    function void note_item(in_t item);
      int      rows;
      int      cols;
      int      sel;
      int      r;
      int      k;
      int      x;
      region_e region;
      out_t    beat;
      if (item.command == CMD_LOAD) begin
        step_table[item.row][item.column] = item.value;
        return;
      end
      rows = (row_count == 0) ? 1 : (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
      cols = (column_count == 0) ? 1 :
             (column_count > MAX_COLS) ? MAX_COLS : int'(column_count);
      x   = item.value;
      sel = 0;
      if (!time_reached(step_table[0][0], x)) begin
        region = REGION_BEFORE;
      end else if (x > step_table[rows-1][0]) begin
        region = REGION_AFTER;
        sel    = rows - 1;
      end else begin
        // Highest row reached wins, which also settles ties and unsorted tables.
        region = REGION_WITHIN;
        for (r = rows - 1; r >= 0; r--) begin
          if (time_reached(step_table[r][0], x)) begin
            sel = r;
            break;
          end
        end
      end
      for (k = 0; k < cols; k++) begin
        beat.column_res = COLUMN_W'(k);
        if (k == 0) begin
          beat.value_res = x;
        end else if (region == REGION_BEFORE) begin
          beat.value_res = '0;
        end else begin
          beat.value_res = step_table[sel][k];
        end
        beat.region    = region;
        beat.row_found = IN_ROW_W'(sel);
        beat.last      = (k == cols - 1);
        pending_beats.push_back(beat);
      end
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        error_count++;
      end
    endfunction

    function void check_beat(out_t got);
      out_t want;
      if (pending_beats.size() == 0) begin
        $error("result column %0d value %0d arrived with no lookup waiting",
               got.column_res, got.value_res);
        error_count++;
        return;
      end
      want = pending_beats.pop_front();
      compare_field("column_res", want.column_res, got.column_res);
      compare_field("value_res", want.value_res, got.value_res);
      compare_field("region", want.region, got.region);
      compare_field("row_found", want.row_found, got.row_found);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sfe_in_if  in_if ();
  sfe_out_if out_if ();

  step_lookup_board board;
  bit               loaded [MAX_ROWS][MAX_COLS];
  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_toggle;
  bit               hold_seen;
  int               hold_left;
  int               cycle_count;

  step_function_evaluator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL step_function_evaluator");
      $finish;
    end
  end

  // Record every transfer on both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      board.note_item(in_if.data);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_beat(out_if.data);
    end
  end

  // Result receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HOLD_CYCLES;
      out_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= !(recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic int random_word();
    case ($urandom_range(0, 7))
      0:       return TIME_MIN;
      1:       return TIME_MAX;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item after random idle cycles and wait for its transfer.
  task automatic send_item(input in_t item);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_load(input int r, input int c, input int word);
    in_t item;
    item.command = CMD_LOAD;
    item.row     = IN_ROW_W'(r);
    item.column  = COLUMN_W'(c);
    item.value   = word;
    loaded[r][c] = 1'b1;
    send_item(item);
  endtask

  // Row and column are unused by a lookup, so they carry random bits.
  task automatic send_query(input int x);
    in_t item;
    item.command = CMD_QUERY;
    item.row     = IN_ROW_W'($urandom);
    item.column  = COLUMN_W'($urandom);
    item.value   = x;
    send_item(item);
  endtask

  // Registers change only while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    board.write_register(idx, CFG_DATA_W'(data));
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Stop offering, wait for every expected beat, then let a trailing load settle.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (board.pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One setting of the registers: load the table in use, then random lookups
  // mixed with stray loads. With fresh clear, only missing entries are loaded.
  // A large table loads only row 0 and its top rows, and its lookups never
  // search below those top rows.
  task automatic run_phase(input int rows_w, input int cols_w, input int open_w,
                           input int query_total, input bit fresh, input int hold_at);
    int          rows;
    int          cols;
    int          r;
    int          c;
    int          q;
    int          x;
    int unsigned step_max;
    longint      t;
    bit          sparse;
    write_register(CFG_ROW_COUNT, rows_w);
    write_register(CFG_COLUMN_COUNT, cols_w);
    write_register(CFG_LEFT_OPEN, open_w);
    rows = (rows_w == 0) ? 1 : (rows_w > MAX_ROWS) ? MAX_ROWS : rows_w;
    cols = (cols_w == 0) ? 1 : (cols_w > MAX_COLS) ? MAX_COLS : cols_w;
    sparse = (rows > SPARSE_ROWS);

    // Ascending jump times, either packed close together or spread over the range.
    if ($urandom_range(0, 1) == 1) begin
      step_max = 8;
      t        = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
    end else begin
      step_max = 32'd4000000000 / rows;
      t        = longint'(TIME_MIN);
      if ($urandom_range(0, 3) != 0) begin
        t += $urandom_range(0, 1 << 20);
      end
    end
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        if ((fresh || !loaded[r][c]) && (!sparse || r == 0 || r >= rows - BAND_ROWS)) begin
          send_load(r, c, (c == 0) ? int'(t) : random_word());
        end
      end
      if ($urandom_range(0, 5) != 0) begin
        t += $urandom_range(1, step_max);
      end
    end

    // Lookups aimed at jump times, their neighbors, the ends and the extremes.
    for (q = 0; q < query_total; q++) begin
      if (q == hold_at) begin
        hold_toggle = ~hold_toggle;
      end
      if (sparse) begin
        // Just above a top row, past the end, or before the first time.
        r = $urandom_range(rows - BAND_ROWS, rows - 1);
        case ($urandom_range(0, 2))
          0:       x = board.step_table[r][0] + 1;
          1:       x = TIME_MAX;
          default: x = board.step_table[0][0] - 1;
        endcase
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          send_load($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                    random_word());
        end
        r = $urandom_range(0, rows - 1);
        case ($urandom_range(0, 5))
          0: x = board.step_table[r][0];
          1: x = board.step_table[r][0] + 1;
          2: x = board.step_table[r][0] - 1;
          3: x = $urandom;
          4: x = ($urandom_range(0, 1) == 1) ? TIME_MIN : TIME_MAX;
          default: begin
            x = ($urandom_range(0, 1) == 1) ? board.step_table[0][0] - 1 :
                                              board.step_table[rows-1][0] + 1;
          end
        endcase
      end
      send_query(x);
    end
    drain();
  endtask

  initial begin
    board         = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ROW_COUNT;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    hold_toggle   = 1'b0;
    hold_seen     = 1'b0;
    hold_left     = 0;
    cycle_count   = 0;
    send_idle_pct = 25;
    recv_idle_pct = 69;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one row, one column, closed on the left.
    send_load(0, 0, 0);
    send_query(0);
    send_query(-1);
    drain();

    // Three rows with a tie at zero and extreme step values.
    write_register(CFG_ROW_COUNT, 3);
    write_register(CFG_COLUMN_COUNT, 3);
    write_register(CFG_LEFT_OPEN, 0);
    send_load(0, 0, -65536);
    send_load(0, 1, TIME_MAX);
    send_load(0, 2, TIME_MIN);
    send_load(1, 0, 0);
    send_load(1, 1, 1);
    send_load(1, 2, -1);
    send_load(2, 0, 0);
    send_load(2, 1, int'(32'h1234_5678));
    send_load(2, 2, int'(32'hedcb_a987));
    send_query(TIME_MIN);
    send_query(-65536);
    send_query(-1);
    send_query(0);
    send_query(1);
    send_query(TIME_MAX);
    drain();

    // Same table with strict comparison.
    write_register(CFG_LEFT_OPEN, 1);
    send_query(-65536);
    send_query(0);
    send_query(1);
    drain();

    // Random part: sender idles lightly, receiver heavily.
    run_phase(5, 3, 0, 30, 1'b1, 10);
    write_register(CFG_IDX_SPARE, 2047);
    run_phase(0, 0, 1, 10, 1'b1, -1);
    run_phase(3, 3, 1, 20, 1'b1, -1);

    // Sender idles heavily, receiver lightly.
    send_idle_pct = 69;
    recv_idle_pct = 25;
    run_phase(3, 15, 1, 16, 1'b1, -1);
    run_phase(1024, 1, 0, 10, 1'b1, -1);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(2047, 1, 1, 8, 1'b0, -1);
    run_phase(1, 8, 0, 20, 1'b1, -1);
    run_phase(10, 2, 0, 20, 1'b1, -1);

    if (board.error_count == 0 && board.pending_beats.size() == 0) begin
      $display("PASS step_function_evaluator");
    end else begin
      $display("FAIL step_function_evaluator");
    end
    $finish;
  end

endmodule
